// ===== hdl/rv32x_pkg.sv =====
package rv32x_pkg;

  typedef enum logic [5:0] {
    OP_LUI = 6'd0, OP_AUIPC = 6'd1, OP_ADDI = 6'd2, OP_SLT = 6'd3, OP_SLTI = 6'd4,
    OP_SLTU = 6'd5, OP_SLTIU = 6'd6, OP_XORI = 6'd7, OP_ORI = 6'd8, OP_ANDI = 6'd9,
    OP_SLLI = 6'd10, OP_SRLI = 6'd11, OP_SRAI = 6'd12, OP_ADD = 6'd13, OP_SUB = 6'd14,
    OP_AND = 6'd15, OP_XOR = 6'd16, OP_OR = 6'd17, OP_SLL = 6'd18, OP_SRL = 6'd19,
    OP_SRA = 6'd20, OP_JAL = 6'd21, OP_JALR = 6'd22, OP_BEQ = 6'd23, OP_BNE = 6'd24,
    OP_BLT = 6'd25, OP_BGE = 6'd26, OP_BLTU = 6'd27, OP_BGEU = 6'd28, OP_LB = 6'd29,
    OP_LH = 6'd30, OP_LW = 6'd31, OP_LBU = 6'd32, OP_LHU = 6'd33, OP_SB = 6'd34,
    OP_SH = 6'd35, OP_SW = 6'd36, OP_HALT = 6'd37, OP_INVALID = 6'd38
  } op_t;

  localparam logic [2:0] ST_RUNNING = 3'd0;
  localparam logic [2:0] ST_HALTED  = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_OOB     = 3'd3;
  localparam logic [2:0] ST_READY   = 3'd4;

  // Back end phases: operand read, then execute and commit
  typedef enum logic [1:0] {S_IDLE, S_EXEC} phase_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [5:0]  mode;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
  } item_t;

endpackage

// ===== hdl/rv32x_front.sv =====
module rv32x_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [55:0]       in_tdata,
  output logic              q_valid,
  input  logic              q_ready,
  output rv32x_pkg::item_t  q_item
);

  // Two-entry queue between front and back
  rv32x_pkg::item_t mem_r [2];
  logic [0:0] wp_r, rp_r;
  logic [1:0] cnt_r;
  rv32x_pkg::item_t it;
  logic push, pop;

  // Unpack the transfer
  always_comb begin
    it.mode = in_tdata[5:0];
    it.rd   = in_tdata[10:6];
    it.rs1  = in_tdata[15:11];
    it.rs2  = in_tdata[20:16];
    it.imm  = in_tdata[52:21];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push = in_tvalid && in_tready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= it;
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hdl/rv32x_back.sv =====
module rv32x_back #(
  parameter int unsigned MEM_BYTES = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  rv32x_pkg::item_t  q_item,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [119:0]      out_tdata
);

  localparam int unsigned BANK_D = (MEM_BYTES + 3) / 4;
  localparam int unsigned RW = (BANK_D > 1) ? $clog2(BANK_D) : 1;

  // Register file
  logic [31:0] rf_r [32];

  logic [31:0] pc_r, cnt_r;
  logic [2:0]  st_r;
  logic [7:0]  code_r;
  rv32x_pkg::phase_t ph_r, ph_nxt;
  rv32x_pkg::item_t it_r;
  logic [31:0] a_r, b_r, x10_r;
  logic [7:0]  ld_r [4];

  // Output register
  logic        ov_r;
  logic [119:0] od_r;

  logic [31:0] a, b, imm, addr, val, npc;
  logic        wb, taken, oob, store;
  logic [2:0]  size;
  logic [32:0] endp;
  logic [2:0]  st_nxt;
  logic [31:0] lw;

  logic          take;
  logic [31:0]   raddr;
  logic [RW-1:0] rd_row [4];
  logic [RW-1:0] wr_row [4];
  logic [7:0]    wr_byte [4];
  logic [3:0]    wr_en;

  logic        commit;
  logic [7:0]  code_nxt;
  logic [31:0] pc_nxt, cnt_nxt;
  logic        wbv;

  assign out_tvalid = ov_r;
  assign out_tdata = od_r;

  // Phase sequencing
  always_comb begin
    ph_nxt = ph_r;
    unique case (ph_r)
      rv32x_pkg::S_IDLE: if (q_valid && q_ready) ph_nxt = rv32x_pkg::S_EXEC;
      rv32x_pkg::S_EXEC: ph_nxt = rv32x_pkg::S_IDLE;
      default: ph_nxt = rv32x_pkg::S_IDLE;
    endcase
  end

  // Take a new item only when idle and the output register is free
  always_comb begin
    q_ready = (ph_r == rv32x_pkg::S_IDLE) && (!ov_r || out_tready);
    take = q_valid && q_ready;
  end

  // Execute using operands captured in the read phase
  always_comb begin
    a = a_r; b = b_r; imm = it_r.imm;
    addr = a + imm;
    val = '0; wb = 1'b0; taken = 1'b0; npc = pc_r + 32'd4;
    store = 1'b0; size = 3'd4;
    // Rotate the bank bytes back into address order
    for (int i = 0; i < 4; i++) lw[8*i +: 8] = ld_r[2'(addr[1:0] + 2'(i))];
    unique case (it_r.mode) inside
      rv32x_pkg::OP_LB, rv32x_pkg::OP_LBU, rv32x_pkg::OP_SB: size = 3'd1;
      rv32x_pkg::OP_LH, rv32x_pkg::OP_LHU, rv32x_pkg::OP_SH: size = 3'd2;
      default: size = 3'd4;
    endcase
    endp = {1'b0, addr} + {30'd0, size};
    oob = endp > 33'(MEM_BYTES);
    unique case (it_r.mode)
      rv32x_pkg::OP_LUI:   begin val = imm; wb = 1'b1; end
      rv32x_pkg::OP_AUIPC: begin val = pc_r + imm; wb = 1'b1; end
      rv32x_pkg::OP_ADDI:  begin val = a + imm; wb = 1'b1; end
      rv32x_pkg::OP_SLT:   begin val = {31'd0, $signed(a) < $signed(b)}; wb = 1'b1; end
      rv32x_pkg::OP_SLTI:  begin val = {31'd0, $signed(a) < $signed(imm)}; wb = 1'b1; end
      rv32x_pkg::OP_SLTU:  begin val = {31'd0, a < b}; wb = 1'b1; end
      rv32x_pkg::OP_SLTIU: begin val = {31'd0, a < imm}; wb = 1'b1; end
      rv32x_pkg::OP_XORI:  begin val = a ^ imm; wb = 1'b1; end
      rv32x_pkg::OP_ORI:   begin val = a | imm; wb = 1'b1; end
      rv32x_pkg::OP_ANDI:  begin val = a & imm; wb = 1'b1; end
      rv32x_pkg::OP_SLLI:  begin val = a << imm[4:0]; wb = 1'b1; end
      rv32x_pkg::OP_SRLI:  begin val = a >> imm[4:0]; wb = 1'b1; end
      rv32x_pkg::OP_SRAI:  begin val = 32'($signed(a) >>> imm[4:0]); wb = 1'b1; end
      rv32x_pkg::OP_ADD:   begin val = a + b; wb = 1'b1; end
      rv32x_pkg::OP_SUB:   begin val = a - b; wb = 1'b1; end
      rv32x_pkg::OP_AND:   begin val = a & b; wb = 1'b1; end
      rv32x_pkg::OP_XOR:   begin val = a ^ b; wb = 1'b1; end
      rv32x_pkg::OP_OR:    begin val = a | b; wb = 1'b1; end
      rv32x_pkg::OP_SLL:   begin val = a << b[4:0]; wb = 1'b1; end
      rv32x_pkg::OP_SRL:   begin val = a >> b[4:0]; wb = 1'b1; end
      rv32x_pkg::OP_SRA:   begin val = 32'($signed(a) >>> b[4:0]); wb = 1'b1; end
      rv32x_pkg::OP_JAL:   begin val = pc_r + 32'd4; wb = 1'b1; npc = pc_r + imm; end
      rv32x_pkg::OP_JALR:  begin
        val = pc_r + 32'd4; wb = 1'b1; npc = (a + imm) & 32'hffff_fffe;
      end
      rv32x_pkg::OP_BEQ:   taken = (a == b);
      rv32x_pkg::OP_BNE:   taken = (a != b);
      rv32x_pkg::OP_BLT:   taken = $signed(a) < $signed(b);
      rv32x_pkg::OP_BGE:   taken = !($signed(a) < $signed(b));
      rv32x_pkg::OP_BLTU:  taken = (a < b);
      rv32x_pkg::OP_BGEU:  taken = (a >= b);
      rv32x_pkg::OP_LB:    begin val = {{24{lw[7]}}, lw[7:0]}; wb = 1'b1; end
      rv32x_pkg::OP_LH:    begin val = {{16{lw[15]}}, lw[15:0]}; wb = 1'b1; end
      rv32x_pkg::OP_LW:    begin val = lw; wb = 1'b1; end
      rv32x_pkg::OP_LBU:   begin val = {24'd0, lw[7:0]}; wb = 1'b1; end
      rv32x_pkg::OP_LHU:   begin val = {16'd0, lw[15:0]}; wb = 1'b1; end
      rv32x_pkg::OP_SB, rv32x_pkg::OP_SH, rv32x_pkg::OP_SW: store = 1'b1;
      default: ;
    endcase
    if (taken) npc = pc_r + imm;
    if (!(it_r.mode >= rv32x_pkg::OP_LB && it_r.mode <= rv32x_pkg::OP_SW)) oob = 1'b0;
    if (it_r.mode >= rv32x_pkg::OP_HALT) oob = 1'b0;
    if (st_r != rv32x_pkg::ST_READY && st_r != rv32x_pkg::ST_RUNNING) st_nxt = st_r;
    else if (it_r.mode == rv32x_pkg::OP_HALT) st_nxt = rv32x_pkg::ST_HALTED;
    else if (it_r.mode > rv32x_pkg::OP_HALT) st_nxt = rv32x_pkg::ST_INVALID;
    else if (oob) st_nxt = rv32x_pkg::ST_OOB;
    else st_nxt = rv32x_pkg::ST_RUNNING;
  end

  assign commit = (st_r == rv32x_pkg::ST_READY || st_r == rv32x_pkg::ST_RUNNING) &&
                  st_nxt == rv32x_pkg::ST_RUNNING;
  assign wbv = commit && wb && (it_r.rd != 5'd0);
  assign pc_nxt = commit ? npc : pc_r;
  assign cnt_nxt = commit ? cnt_r + 32'd1 : cnt_r;
  assign code_nxt = (st_nxt == rv32x_pkg::ST_HALTED && st_r != rv32x_pkg::ST_HALTED) ?
                    x10_r[7:0] : code_r;

  // Bank rows and byte lanes: byte i of an access lands in bank (addr + i) mod 4
  always_comb begin
    logic [1:0] off;
    raddr = q_item.imm + rf_r[q_item.rs1];
    for (int k = 0; k < 4; k++) begin
      off = 2'(k) - addr[1:0];
      rd_row[k] = (2'(k) >= raddr[1:0]) ? raddr[RW+1:2] : raddr[RW+1:2] + 1'b1;
      wr_row[k] = (2'(k) >= addr[1:0]) ? addr[RW+1:2] : addr[RW+1:2] + 1'b1;
      wr_byte[k] = b_r[{off, 3'b000} +: 8];
      wr_en[k] = (ph_r == rv32x_pkg::S_EXEC) && commit && store && ({1'b0, off} < size);
    end
  end

  // Data memory as four byte banks, each read and written at one row a cycle
  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [7:0] mem_r [BANK_D];
    always_ff @(posedge clk) begin
      if (take) ld_r[k] <= mem_r[rd_row[k]];
      if (wr_en[k]) mem_r[wr_row[k]] <= wr_byte[k];
    end
  end

  // Read phase: capture operands; execute phase: load the result
  always_ff @(posedge clk) begin
    if (take) begin
      it_r <= q_item;
      a_r <= rf_r[q_item.rs1];
      b_r <= rf_r[q_item.rs2];
      x10_r <= rf_r[10];
    end
    if (ph_r == rv32x_pkg::S_EXEC) begin
      od_r <= {7'd0, cnt_nxt, code_nxt, wbv ? val : 32'd0,
               wbv ? it_r.rd : 5'd0, wbv, pc_nxt, st_nxt};
    end
  end

  // Commit architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) rf_r[i] <= '0;
      pc_r <= '0; cnt_r <= '0; code_r <= '0;
      st_r <= rv32x_pkg::ST_READY;
      ph_r <= rv32x_pkg::S_IDLE;
      ov_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt;
      if (ph_r == rv32x_pkg::S_EXEC) begin
        if (wbv) rf_r[it_r.rd] <= val;
        ov_r <= 1'b1;
        pc_r <= pc_nxt; cnt_r <= cnt_nxt; code_r <= code_nxt; st_r <= st_nxt;
      end else if (out_tvalid && out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/rv32i_execute_step_top.sv =====
// Channel | Ports              | Contents
// input   | in_t*              | tdata: mode, dest_reg, src1_reg, src2_reg, immediate
// result  | out_t*             | tdata: status, next_pc, register write, exit_code, retired_count
// The back end handles each instruction as an operand and memory read, then an
// execute and write back; the register file read-after-write sets this split.
// A two-entry queue takes transfers while the back end works or the result waits.
// Reset is synchronous, active low; the data memory is not cleared.
module rv32i_execute_step_top #(
  parameter int unsigned MEM_BYTES = 65536
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [55:0]  in_tdata,   // mode, dest_reg, src1_reg, src2_reg, immediate
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata   // status, next_pc, writeback_valid, writeback_reg,
                                   // written value, exit_code, retired_count
);

  logic q_valid, q_ready;
  rv32x_pkg::item_t q_item;

  rv32x_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .q_valid, .q_ready, .q_item
  );

  rv32x_back #(.MEM_BYTES(MEM_BYTES)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_item,
    .out_tvalid, .out_tready, .out_tdata
  );

endmodule
